@@ rtl/core/teq_pkg.sv @@
// Package for the timed event queue: field widths, request and status codes, shared types.
package teq_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;

  // Request codes carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_POST   = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_POLL   = 2'd3
  } req_e;

  // Status codes returned with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_POSTED      = 3'd0,
    ST_DROPPED     = 3'd1,
    ST_CANCELLED   = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_DELIVERED   = 3'd4,
    ST_NOTHING_DUE = 3'd5,
    ST_TICKED      = 3'd6
  } status_e;

  // What the cell row does in the current cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } cell_op_e;

  // One pending entry.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    cell_op_e op;
    entry_t   key;
  } cell_cmd_t;

endpackage

@@ rtl/core/teq_req_if.sv @@
// Request channel interface of the timed event queue.
interface teq_req_if
  import teq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ID_W-1:0]    msg_id;
  logic [DELAY_W-1:0] delay;

  modport source (output valid, output req_type, output msg_id, output delay, input ready);
  modport sink   (input valid, input req_type, input msg_id, input delay, output ready);
endinterface

@@ rtl/core/teq_rsp_if.sv @@
// Response channel interface of the timed event queue.
interface teq_rsp_if
  import teq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_msg_id;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output out_msg_id, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_msg_id, input occupancy,
                  output ready);
endinterface

@@ rtl/core/teq_cell.sv @@
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module teq_cell
  import teq_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      valid_i,
  input  logic      prev_keep_i,
  input  logic      prev_hit_i,
  input  entry_t    prev_entry_i,
  input  entry_t    next_entry_i,
  output logic      keep_o,
  output logic      hit_o,
  output entry_t    entry_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   match;

  // Compare the stored entry with the broadcast key.
  assign keep_o  = valid_i && (entry_q.deadline <= cmd_i.key.deadline);
  assign match   = valid_i && (entry_q.id == cmd_i.key.id);
  assign hit_o   = prev_hit_i || match;
  assign entry_o = entry_q;

  // Choose between holding, taking the new entry, or shifting from a neighbor.
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (!keep_o) begin
          entry_d = prev_keep_i ? cmd_i.key : prev_entry_i;
        end
      end
      OP_REMOVE: begin
        if (hit_o) begin
          entry_d = next_entry_i;
        end
      end
      OP_POP: begin
        entry_d = next_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/core/timed_event_queue.sv @@
// Timed event queue: a tick counter and a deadline-sorted row of pending message ids.
//
// Requests arrive on req_i (post, cancel, tick, poll) and each produces exactly one
// response on rsp_o with a status, the delivered id and the occupancy after the request.
// A post stores its message at deadline time + delay, behind every entry with an
// earlier or equal deadline; a cancel removes the first entry with the id; a tick
// advances time by one; a poll delivers the head entry when its deadline has come.
// The entries live in a row of QUEUE_DEPTH cells; every cell compares its entry with
// the request in parallel and takes its new entry from itself, the request or a
// neighbor, so the whole row is updated together for each request.
// The response is registered and valid in the cycle after the request transfer.
// Throughput: one request per cycle while the receiver takes responses; the single
// response register lets a new request transfer in the same cycle as the old response.
// When the receiver stalls, the response is held and req_i.ready is low until taken.
// Reset clears time, the entry count and the response valid; cell contents are
// unused until written.
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  teq_req_if.sink   req_i,
  teq_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_W-1:0] time_q, time_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              rsp_valid_q;
  status_e           status_q, status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [OCC_W-1:0]  occ_q;

  logic      xfer;
  logic      full;
  logic      head_due;
  logic      found;
  req_e      req;
  cell_cmd_t cmd;

  logic   keep  [QUEUE_DEPTH];
  logic   hit   [QUEUE_DEPTH];
  entry_t entry [QUEUE_DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign xfer        = req_i.valid && req_i.ready;
  assign req         = req_e'(req_i.req_type);
  assign full        = (count_q == CntW'(QUEUE_DEPTH));
  assign head_due    = (count_q != '0) && (entry[0].deadline <= time_q);
  assign found       = hit[QUEUE_DEPTH-1];

  // Decode the request into a cell command and the next control state.
  always_comb begin
    cmd.key.deadline = time_q + {{(TIME_W - DELAY_W){1'b0}}, req_i.delay};
    cmd.key.id       = req_i.msg_id;
    cmd.op           = OP_HOLD;
    time_d           = time_q;
    count_d          = count_q;
    status_d         = status_q;
    out_id_d         = '0;
    case (req)
      REQ_POST: begin
        if (full) begin
          status_d = ST_DROPPED;
        end else begin
          cmd.op   = xfer ? OP_INSERT : OP_HOLD;
          count_d  = count_q + CntW'(1);
          status_d = ST_POSTED;
        end
      end
      REQ_CANCEL: begin
        if (found) begin
          cmd.op   = xfer ? OP_REMOVE : OP_HOLD;
          count_d  = count_q - CntW'(1);
          status_d = ST_CANCELLED;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      REQ_TICK: begin
        time_d   = time_q + TIME_W'(1);
        status_d = ST_TICKED;
      end
      default: begin
        if (head_due) begin
          cmd.op   = xfer ? OP_POP : OP_HOLD;
          count_d  = count_q - CntW'(1);
          out_id_d = entry[0].id;
          status_d = ST_DELIVERED;
        end else begin
          status_d = ST_NOTHING_DUE;
        end
      end
    endcase
  end

  // The row of cells, each linked to its neighbors.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   valid;
    logic   prev_keep;
    logic   prev_hit;
    entry_t prev_entry;
    entry_t next_entry;

    assign valid = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_keep  = 1'b1;
      assign prev_hit   = 1'b0;
      assign prev_entry = cmd.key;
    end else begin : g_inner
      assign prev_keep  = keep[i-1];
      assign prev_hit   = hit[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    teq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (valid),
      .prev_keep_i  (prev_keep),
      .prev_hit_i   (prev_hit),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .keep_o       (keep[i]),
      .hit_o        (hit[i]),
      .entry_o      (entry[i])
    );
  end

  // Control state and the response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        time_q      <= time_d;
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload is loaded with every request transfer.
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      status_q <= status_d;
      out_id_q <= out_id_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.out_msg_id = out_id_q;
  assign rsp_o.occupancy  = occ_q;

endmodule

@@ test/timed_event_queue_tb.sv @@
// Self-checking testbench of the timed event queue: directed and random requests.
`timescale 1ns / 100ps

module timed_event_queue_tb
  import teq_pkg::*;
;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Mixes of request kinds used by the random phases.
  typedef enum int unsigned {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } mix_e;

  // One expected response.
  typedef struct {
    status_e          status;
    logic [ID_W-1:0]  msg_id;
    logic [OCC_W-1:0] occupancy;
  } reply_t;

  // Keeps a copy of the queue state, predicts each response and checks it.
  class teq_scoreboard;
    logic [TIME_W-1:0] now_ticks;
    logic [TIME_W-1:0] due_at [QUEUE_DEPTH];
    logic [ID_W-1:0]   held_id [QUEUE_DEPTH];
    int unsigned       held;
    reply_t            awaited_replies [$];
    int unsigned       mismatches;

    function new();
      now_ticks = '0;
      held = 0;
      mismatches = 0;
      foreach (due_at[i]) begin
        due_at[i] = '0;
        held_id[i] = '0;
      end
    endfunction

    // Closes the gap left by the entry at pos.
    function void drop_entry(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < held; i++) begin
        due_at[i] = due_at[i + 1];
        held_id[i] = held_id[i + 1];
      end
      held--;
    endfunction

    // An id that is pending now; only called while the queue holds entries.
    function logic [ID_W-1:0] pending_id();
      return held_id[$urandom_range(0, held - 1)];
    endfunction

    // Applies one accepted request to the state and queues its response.
    function void note_request(req_e kind, logic [ID_W-1:0] id, logic [DELAY_W-1:0] dly);
      reply_t            reply;
      logic [TIME_W-1:0] when;
      int unsigned       pos;
      int unsigned       i;
      reply.msg_id = '0;
      case (kind)
        REQ_POST: begin
          if (held >= QUEUE_DEPTH) begin
            reply.status = ST_DROPPED;
          end else begin
            when = now_ticks + TIME_W'(dly);
            pos = 0;
            while (pos < held && due_at[pos] <= when) pos++;
            for (i = held; i > pos; i--) begin
              due_at[i] = due_at[i - 1];
              held_id[i] = held_id[i - 1];
            end
            due_at[pos] = when;
            held_id[pos] = id;
            held++;
            reply.status = ST_POSTED;
          end
        end
        REQ_CANCEL: begin
          reply.status = ST_NOT_FOUND;
          for (i = 0; i < held; i++) begin
            if (held_id[i] == id) begin
              drop_entry(i);
              reply.status = ST_CANCELLED;
              break;
            end
          end
        end
        REQ_TICK: begin
          now_ticks = now_ticks + 1'b1;
          reply.status = ST_TICKED;
        end
        default: begin
          if (held > 0 && due_at[0] <= now_ticks) begin
            reply.msg_id = held_id[0];
            drop_entry(0);
            reply.status = ST_DELIVERED;
          end else begin
            reply.status = ST_NOTHING_DUE;
          end
        end
      endcase
      reply.occupancy = OCC_W'(held);
      awaited_replies.push_back(reply);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // Compares one accepted response with the oldest expectation.
    task check_response(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id, logic [OCC_W-1:0] occ);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        report($sformatf("response with nothing expected, status %0d", st));
      end else begin
        want = awaited_replies.pop_front();
        if (st !== want.status)
          report($sformatf("status %0d, expected %s", st, want.status.name()));
        if (id !== want.msg_id)
          report($sformatf("out_msg_id %h, expected %h", id, want.msg_id));
        if (occ !== want.occupancy)
          report($sformatf("occupancy %0d, expected %0d", occ, want.occupancy));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic req_quiet;
  logic rsp_quiet;

  teq_scoreboard book;

  teq_req_if req_if ();
  teq_rsp_if rsp_if ();

  timed_event_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drives one request after a random gap and waits for its transfer.
  task automatic send_request(input req_e kind, input logic [ID_W-1:0] id,
                              input logic [DELAY_W-1:0] dly);
    int unsigned gap;
    gap = req_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.msg_id   <= id;
    req_if.delay    <= dly;
    do @(posedge clk); while (!req_if.ready);
    book.note_request(kind, id, dly);
  endtask

  // Draws a delay: mostly short so that entries come due, sometimes far or extreme.
  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 13) return DELAY_W'($urandom_range(0, 5));
    if (roll < 18) return DELAY_W'($urandom_range(0, 40));
    if (roll == 18) return $urandom;
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // Draws an id from a small pool, so that duplicates occur, or from the whole range.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return ID_W'($urandom);
    return ID_W'($urandom_range(0, 7));
  endfunction

  // Sends one random request of the given mix.
  task automatic random_request(input mix_e mix);
    int unsigned     roll;
    int unsigned     post_top;
    int unsigned     cancel_top;
    int unsigned     tick_top;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin post_top = 60; cancel_top = 70; tick_top = 80; end
      MIX_DRAIN: begin post_top = 15; cancel_top = 25; tick_top = 60; end
      default:   begin post_top = 35; cancel_top = 50; tick_top = 75; end
    endcase
    if (roll < post_top) begin
      send_request(REQ_POST, pick_id(), pick_delay());
    end else if (roll < cancel_top) begin
      if (book.held > 0 && $urandom_range(0, 9) < 7) id = book.pending_id();
      else id = pick_id();
      send_request(REQ_CANCEL, id, $urandom);
    end else if (roll < tick_top) begin
      send_request(REQ_TICK, ID_W'($urandom), $urandom);
    end else begin
      send_request(REQ_POLL, ID_W'($urandom), $urandom);
    end
  endtask

  // Holds the sender until every expected response has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (book.awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Response side: random stalls before each transfer, then the check.
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rsp_quiet ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      book.check_response(rsp_if.status, rsp_if.out_msg_id, rsp_if.occupancy);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence: reset, directed requests, random phases, drain and verdict.
  initial begin
    book = new();
    req_quiet = 1'b0;
    rsp_quiet = 1'b0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_POST;
    req_if.msg_id   <= '0;
    req_if.delay    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue: nothing due and nothing to cancel.
    send_request(REQ_POLL, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_CANCEL, 16'h0000, 32'h0000_0000);
    // Extreme ids and delays, equal deadlines leaving in arrival order.
    send_request(REQ_POST, 16'hFFFF, 32'h0000_0000);
    send_request(REQ_POST, 16'h0000, 32'hFFFF_FFFF);
    send_request(REQ_POST, 16'h1234, 32'h0000_0000);
    send_request(REQ_POST, 16'h5555, 32'h0000_0000);
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);
    send_request(REQ_POLL, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_CANCEL, 16'h5555, 32'hFFFF_FFFF);
    // Head entry not yet due.
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);
    send_request(REQ_CANCEL, 16'h0000, 32'h0000_0000);
    // Short delays with a duplicated id, released by ticks.
    send_request(REQ_POST, 16'hAAAA, 32'h0000_0002);
    send_request(REQ_POST, 16'h7777, 32'h0000_0001);
    send_request(REQ_POST, 16'hAAAA, 32'h0000_0001);
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);
    send_request(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);
    send_request(REQ_CANCEL, 16'hAAAA, 32'h0000_0000);
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);
    send_request(REQ_TICK, 16'h0000, 32'h0000_0000);
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);
    send_request(REQ_CANCEL, 16'hAAAA, 32'h0000_0000);
    send_request(REQ_POLL, 16'h0000, 32'h0000_0000);

    // Random phases with changing mixes and idling; the sender drains after each.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      req_quiet = (ph == 3);
      rsp_quiet = (ph == 1 || ph == 3);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1) random_request(MIX_FILL);
        else random_request(mix_e'(ph % 3));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.awaited_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
